// ===== sv/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list: payload structs,
// command and status codes, controller states and the control/status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 5;
  localparam int CNT_OUT_W    = 5;
  localparam int STATUS_W     = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_END   = 3'd0,
    CMD_INS_START = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_REM_END   = 3'd3,
    CMD_REM_START = 3'd4,
    CMD_REM_AT    = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_DRAIN,
    S_FINISH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic [STATUS_W-1:0]       status;
    logic [CNT_OUT_W-1:0]      entry_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // capture the accepted command
    logic decode;    // latch status, target index and move count
    logic step;      // issue one entry read of the shift
    logic finish;    // final insert write and count update
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;        // decoded command fails
    logic no_shift;   // nothing to move
    logic last_read;  // current read is the last of the shift
    logic out_busy;   // result register still holds an untaken result
  } dp_stat_t;

endpackage

// ===== sv/positional_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Bounded, densely packed list of signed 32-bit values with insert and remove
// at end, start or a given position; one result per command.
// ----------------------------------------------------------------------------
// One command is handled at a time. A command that fails its checks goes from
// decode straight to the result; a command that moves no entries (an insert at
// the current end, by any insert command) passes decode and finish; any other
// command passes decode, one shift read per entry from the target index to the
// end of the list (at most CAPACITY reads), a drain step and finish. A result
// is loaded only once the previous one has been taken, and the controller
// returns to idle before the next command is accepted. The entries live in a RAM
// with one write and one read port, and the shift moves one entry per cycle
// through it. A new command is taken once the previous result has been loaded,
// even if it has not yet been transferred out. The list starts empty after
// reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module positional_array_list_unit
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t ctrl;
  dp_stat_t  dp_stat;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dp_stat  (dp_stat),
    .ctrl     (ctrl)
  );

  pal_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .dp_stat   (dp_stat)
  );

endmodule

// ===== sv/pal_ram.sv =====
// ----------------------------------------------------------------------------
// pal_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No reset on the array.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== sv/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Command sequencer: accepts a command, has the datapath decode it, steps the
// entry shift one read per cycle, finishes the update and hands off the
// result.
// ----------------------------------------------------------------------------
module pal_ctrl
  import pal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  dp_stat,
  output ctrl_cmd_t ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (dp_stat.err)           state_nxt = S_RESULT;
        else if (dp_stat.no_shift) state_nxt = S_FINISH;
        else                       state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (dp_stat.last_read) state_nxt = S_DRAIN;
      end
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_RESULT;
      S_RESULT: begin
        if (!dp_stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = rst_n;
        ctrl.load_in = in_valid;
      end
      S_DECODE: ctrl.decode = 1'b1;
      S_SHIFT:  ctrl.step   = 1'b1;
      S_DRAIN:  ;
      S_FINISH: ctrl.finish = 1'b1;
      S_RESULT: ctrl.load_out = !dp_stat.out_busy;
      default:  ;
    endcase
  end

endmodule

// ===== sv/pal_dp.sv =====
// ----------------------------------------------------------------------------
// pal_dp
// List datapath: command registers, decode of status and target index, fill
// count, entry RAM with a one-entry-per-cycle shift pipeline, and the result
// register.
// ----------------------------------------------------------------------------
module pal_dp
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  output out_item_t out_data,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_cmd_t ctrl,
  output dp_stat_t  dp_stat
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // captured command
  logic [CMD_W-1:0]   cmd_r;
  logic [VALUE_W-1:0] val_r;
  logic [POS_W-1:0]   pos_r;

  // list and operation state
  logic [CW-1:0]      count_r;
  status_t            status_r;
  logic               is_ins_r;
  logic [AW-1:0]      at_r;
  logic [CW-1:0]      rem_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [AW-1:0]      rd_addr_r;
  logic               rd_fire_r;
  logic               first_r;
  logic [VALUE_W-1:0] got_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  // decode
  logic [CMPW-1:0]    cnt_x, pos_x, at_x;
  logic               full, empty;
  status_t            dec_st;
  logic               dec_ins;
  logic [CW-1:0]      dec_rem;
  logic [AW-1:0]      dec_ptr;

  // RAM ports
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;
  logic               take_got;

  // status and target index of the captured command
  always_comb begin
    cnt_x   = CMPW'(count_r);
    pos_x   = CMPW'(pos_r);
    full    = (count_r == CW'(CAPACITY));
    empty   = (count_r == '0);
    at_x    = '0;
    dec_ins = 1'b0;
    dec_st  = ST_OK;
    case (cmd_t'(cmd_r))
      CMD_INS_END: begin
        dec_ins = 1'b1;
        at_x    = cnt_x;
        dec_st  = full ? ST_FULL : ST_OK;
      end
      CMD_INS_START: begin
        dec_ins = 1'b1;
        dec_st  = full ? ST_FULL : ST_OK;
      end
      CMD_INS_AT: begin
        dec_ins = 1'b1;
        at_x    = pos_x;
        if (full)               dec_st = ST_FULL;
        else if (pos_x > cnt_x) dec_st = ST_BADPOS;
      end
      CMD_REM_END: begin
        at_x   = cnt_x - 1'b1;
        dec_st = empty ? ST_EMPTY : ST_OK;
      end
      CMD_REM_START: begin
        dec_st = empty ? ST_EMPTY : ST_OK;
      end
      CMD_REM_AT: begin
        at_x = pos_x;
        if (empty)               dec_st = ST_EMPTY;
        else if (pos_x >= cnt_x) dec_st = ST_BADPOS;
      end
      default: dec_st = ST_BADPOS;
    endcase
    // entries to read: count - at for both directions
    dec_rem = CW'(cnt_x - at_x);
    // insert walks down from the top entry, remove walks up from the target
    dec_ptr = dec_ins ? AW'(count_r - 1'b1) : AW'(at_x);
  end

  assign dp_stat.err       = (dec_st != ST_OK);
  assign dp_stat.no_shift  = (dec_rem == '0);
  assign dp_stat.last_read = (rem_r == CW'(1));
  assign dp_stat.out_busy  = out_valid_r && !out_ready;

  // first read of a removal is the removed value, not a move
  assign take_got = rd_fire_r && !is_ins_r && first_r;

  // RAM access: reads step through the span, each move write follows in the cycle after its read
  always_comb begin
    ram_re    = ctrl.step;
    ram_we    = 1'b0;
    ram_waddr = at_r;
    ram_wdata = val_r;
    if (rd_fire_r && !take_got) begin
      ram_we    = 1'b1;
      ram_waddr = is_ins_r ? AW'(rd_addr_r + 1'b1) : AW'(rd_addr_r - 1'b1);
      ram_wdata = ram_rdata;
    end else if (ctrl.finish && is_ins_r) begin
      ram_we = 1'b1;
    end
  end

  pal_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_fire_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_fire_r <= ctrl.step;
      if (ctrl.finish) begin
        count_r <= is_ins_r ? CW'(count_r + 1'b1) : CW'(count_r - 1'b1);
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= in_data.command;
      val_r <= in_data.value;
      pos_r <= in_data.position;
    end
    if (ctrl.decode) begin
      status_r <= dec_st;
      is_ins_r <= dec_ins;
      at_r     <= AW'(at_x);
      rem_r    <= dec_rem;
      rd_ptr_r <= dec_ptr;
      first_r  <= 1'b1;
    end
    if (ctrl.step) begin
      rd_addr_r <= rd_ptr_r;
      rem_r     <= CW'(rem_r - 1'b1);
      rd_ptr_r  <= is_ins_r ? AW'(rd_ptr_r - 1'b1) : AW'(rd_ptr_r + 1'b1);
    end
    if (take_got) begin
      got_r   <= ram_rdata;
      first_r <= 1'b0;
    end
    if (ctrl.load_out) begin
      out_data_r.removed_value <= (status_r == ST_OK && !is_ins_r) ? got_r : '1;
      out_data_r.status        <= status_r;
      out_data_r.entry_count   <= CNT_OUT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/pal_checker.sv =====
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks of the positional array list, bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // one command at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  // failed commands report minus one
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.removed_value == '1)
    else $error("error result carries a removed value");

  // full status only at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL
      |-> out_data.entry_count == CNT_OUT_W'(CAPACITY))
    else $error("full status with count below capacity");

  // empty status only with no entries
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.entry_count == '0)
    else $error("empty status with entries held");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind positional_array_list_unit pal_checker #(
  .CAPACITY(CAPACITY)
) u_pal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_positional_array_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_array_list_unit
// Self-checking bench for the positional array list. A directed table takes
// the list through empty, bad-position, unused-command and full cases, then
// random fill/drain sweeps run under three sender/receiver idling mixes. Each
// result is checked field by field against a fixed one or a queue-based model.
// ----------------------------------------------------------------------------
module tb_positional_array_list_unit;
  import pal_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int DIR_ROWS     = 25;
  localparam int RAND_PER_MIX = 200;
  localparam int TAIL_CYCLES  = 4 * (LIST_DEPTH + 4);
  localparam int CYCLE_LIMIT  = 300000;

  // codes outside the command set; the block must flag them as bad position
  localparam logic [CMD_W-1:0]          CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0]          CMD_UNUSED_7 = 3'd7;
  localparam logic signed [VALUE_W-1:0] NO_VALUE     = -32'sd1;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;   // result below is fixed, not predicted
    out_item_t result;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // list contents as the block should hold them, index 0 first
  logic signed [VALUE_W-1:0] list_model[$];
  out_item_t                 pending_results[$];
  int                        fail_count  = 0;
  int                        cycle_count = 0;
  int                        tx_idle_pct = 0;
  int                        rx_idle_pct = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{CMD_REM_END,   32'sd0, 5'd0},  1'b1, '{NO_VALUE, ST_EMPTY,  5'd0}},
    '{'{CMD_REM_AT,    32'sd0, 5'd0},  1'b1, '{NO_VALUE, ST_EMPTY,  5'd0}},
    '{'{CMD_INS_AT,    32'sd9, 5'd1},  1'b1, '{NO_VALUE, ST_BADPOS, 5'd0}},
    '{'{CMD_UNUSED_6,  32'sd9, 5'd0},  1'b1, '{NO_VALUE, ST_BADPOS, 5'd0}},
    '{'{CMD_INS_END,   32'h7FFF_FFFF, 5'd0},  1'b1, '{NO_VALUE, ST_OK, 5'd1}},
    '{'{CMD_INS_START, 32'h8000_0000, 5'd0},  1'b1, '{NO_VALUE, ST_OK, 5'd2}},
    '{'{CMD_INS_AT,    32'hFFFF_FFFF, 5'd1},  1'b1, '{NO_VALUE, ST_OK, 5'd3}},
    '{'{CMD_INS_AT,    32'h0000_0000, 5'd3},  1'b0, '0},
    '{'{CMD_REM_AT,    32'sd0, 5'd4},  1'b1, '{NO_VALUE, ST_BADPOS, 5'd4}},
    // fill up to capacity, ending with inserts at the current end
    '{'{CMD_INS_END,   32'h5555_5555, 5'd0},  1'b0, '0},
    '{'{CMD_INS_START, 32'hAAAA_AAAA, 5'd0},  1'b0, '0},
    '{'{CMD_INS_AT,    32'h0000_0001, 5'd2},  1'b0, '0},
    '{'{CMD_INS_AT,    32'hFFFF_FFFE, 5'd0},  1'b0, '0},
    '{'{CMD_INS_END,   32'h1234_5678, 5'd0},  1'b0, '0},
    '{'{CMD_INS_AT,    32'h8000_0001, 5'd5},  1'b0, '0},
    '{'{CMD_INS_START, 32'h7FFF_FFFE, 5'd0},  1'b0, '0},
    '{'{CMD_INS_AT,    32'h0F0F_0F0F, 5'd8},  1'b0, '0},
    '{'{CMD_INS_END,   32'hF0F0_F0F0, 5'd0},  1'b0, '0},
    '{'{CMD_INS_AT,    32'h3C3C_3C3C, 5'd13}, 1'b0, '0},
    '{'{CMD_INS_AT,    32'hC3C3_C3C3, 5'd14}, 1'b0, '0},
    '{'{CMD_INS_AT,    32'h0000_FFFF, 5'd15}, 1'b0, '0},
    // a full list rejects inserts, also one at the current end
    '{'{CMD_INS_END,   32'sd5, 5'd0},  1'b1, '{NO_VALUE, ST_FULL, 5'd16}},
    '{'{CMD_INS_AT,    32'sd5, 5'd16}, 1'b1, '{NO_VALUE, ST_FULL, 5'd16}},
    '{'{CMD_REM_AT,    32'sd0, 5'd15}, 1'b0, '0},
    '{'{CMD_REM_START, 32'sd0, 5'd0},  1'b0, '0}
  };

  positional_array_list_unit #(
    .CAPACITY (LIST_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // apply one command to the list model and return the result it gives
  function automatic out_item_t apply_list_cmd(input in_item_t item);
    out_item_t res;
    int        fill;
    int        idx;
    fill              = list_model.size();
    res.removed_value = NO_VALUE;
    res.status        = ST_BADPOS;
    case (item.command)
      CMD_INS_END, CMD_INS_START, CMD_INS_AT: begin
        if (item.command == CMD_INS_END) idx = fill;
        else if (item.command == CMD_INS_START) idx = 0;
        else idx = item.position;
        if (fill >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (idx <= fill) begin
          list_model.insert(idx, item.value);
          res.status = ST_OK;
        end
      end
      CMD_REM_END, CMD_REM_START, CMD_REM_AT: begin
        if (item.command == CMD_REM_END) idx = fill - 1;
        else if (item.command == CMD_REM_START) idx = 0;
        else idx = item.position;
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else if (idx < fill) begin
          res.removed_value = list_model[idx];
          list_model.delete(idx);
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_OUT_W'(list_model.size());
    return res;
  endfunction

  // offer one command, wait for its transfer, then log what it should return
  task automatic send_cmd(input in_item_t item, input logic typed, input out_item_t fixed_res);
    out_item_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_list_cmd(item);
    pending_results.push_back(typed ? fixed_res : predicted);
  endtask

  // random commands that sweep the list between empty and full
  task automatic run_random(input int count);
    in_item_t item;
    logic     filling;
    int       pick;
    int       fill;
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      fill = list_model.size();
      if (fill == LIST_DEPTH) filling = 1'b0;
      if (fill == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      item.value    = $urandom;
      item.position = POS_W'($urandom_range(0, LIST_DEPTH));
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       item.value = 32'h8000_0000;
          1:       item.value = 32'h7FFF_FFFF;
          2:       item.value = 32'h0000_0000;
          default: item.value = NO_VALUE;
        endcase
      end
      if (pick < 3) begin
        item.command = $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
      end else if (filling ? (pick < 75) : (pick < 30)) begin
        case ($urandom_range(0, 2))
          0:       item.command = CMD_INS_END;
          1:       item.command = CMD_INS_START;
          default: item.command = CMD_INS_AT;
        endcase
        if ($urandom_range(0, 9) != 0) item.position = POS_W'($urandom_range(0, fill));
      end else begin
        case ($urandom_range(0, 2))
          0:       item.command = CMD_REM_END;
          1:       item.command = CMD_REM_START;
          default: item.command = CMD_REM_AT;
        endcase
        if ($urandom_range(0, 9) != 0 && fill > 0) begin
          item.position = POS_W'($urandom_range(0, fill - 1));
        end
      end
      send_cmd(item, 1'b0, '0);
    end
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: removed_value %0d status %0d entry_count %0d",
               out_data.removed_value, out_data.status, out_data.entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, got %0d",
                 want.removed_value, out_data.removed_value);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_data.entry_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    tx_idle_pct = 26;
    rx_idle_pct = 70;
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_cmd(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].result);
    end
    run_random(RAND_PER_MIX);

    // swapped idling
    tx_idle_pct = 70;
    rx_idle_pct = 26;
    run_random(RAND_PER_MIX);

    // back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RAND_PER_MIX);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pal_pkg.sv
sv/pal_ram.sv
sv/pal_ctrl.sv
sv/pal_dp.sv
sv/positional_array_list_unit.sv
sv/pal_checker.sv
tb/sv/tb_positional_array_list_unit.sv
